// File: hw/rtl/permutation_mutation_engine_core_macros.svh
// Assertion helpers for the mutation engine checker
`ifndef PERMUTATION_MUTATION_ENGINE_CORE_MACROS_SVH
`define PERMUTATION_MUTATION_ENGINE_CORE_MACROS_SVH

// same-cycle implication, off while in reset
`define PME_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off while in reset
`define PME_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication, also checked through reset
`define PME_ASSERT_NXT_RAW(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/pme_pkg.sv
// ----------------------------------------------------------------------------
// pme_pkg
// Shared constants, operation codes and the result record of the engine.
// ----------------------------------------------------------------------------
package pme_pkg;

    localparam int MAX_CITIES_DEF = 64;
    localparam int CITY_W         = 6;
    localparam int NUM_CODES      = 1 << CITY_W;
    localparam int FIELD_W        = 7;
    localparam int AMOUNT_W       = 6;
    localparam int KIND_W         = 3;

    localparam logic [KIND_W-1:0] KIND_IDENT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SWAP  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_INV   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FWD   = 3'd5;
    localparam logic [KIND_W-1:0] KIND_BWD   = 3'd6;
    localparam logic [KIND_W-1:0] KIND_CHECK = 3'd7;

    typedef struct packed {
        logic              valid;
        logic [CITY_W-1:0] read_value;
        logic              applied;
        logic              no_repeat;
        logic              starts_home;
    } res_t;

endpackage

// File: hw/rtl/pme_ram.sv
// ----------------------------------------------------------------------------
// pme_ram
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
module pme_ram #(
    parameter int DEPTH = pme_pkg::MAX_CITIES_DEF,
    parameter int W     = pme_pkg::CITY_W
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [W-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [W-1:0]                           rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/pme_ctrl.sv
// ----------------------------------------------------------------------------
// pme_ctrl
// Operation sequencer: guards, tour and scratch memory traffic, check scan.
// ----------------------------------------------------------------------------
module pme_ctrl #(
    parameter int MAX_CITIES = pme_pkg::MAX_CITIES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [pme_pkg::FIELD_W-1:0]   city_count,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic [pme_pkg::KIND_W-1:0]    kind,
    input  logic [pme_pkg::FIELD_W-1:0]   first_index,
    input  logic [pme_pkg::FIELD_W-1:0]   second_index,
    input  logic [pme_pkg::AMOUNT_W-1:0]  amount,
    input  logic [pme_pkg::CITY_W-1:0]    city_value,
    output pme_pkg::res_t                 res,
    input  logic                          res_ack
);

    localparam int IDX_W = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
    localparam int AW    = (IDX_W > 8) ? IDX_W : 8;
    localparam int KW    = AW + 1;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_RDOUT = 4'd3;
    localparam logic [3:0] S_PA    = 4'd4;
    localparam logic [3:0] S_PB    = 4'd5;
    localparam logic [3:0] S_PW1   = 4'd6;
    localparam logic [3:0] S_PW2   = 4'd7;
    localparam logic [3:0] S_C1    = 4'd8;
    localparam logic [3:0] S_C2    = 4'd9;
    localparam logic [3:0] S_CK    = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0]                   state_reg, state_next;
    logic [KW-1:0]                k_reg;
    logic [AW-1:0]                kd_reg;
    logic                         pend_reg;
    logic [AW-1:0]                lo_reg, len_reg, r_reg, p_reg, q_reg, pairs_reg, a_reg;
    logic [pme_pkg::CITY_W-1:0]   va_reg, rd_reg;
    logic                         op_reg, ok_reg, norep_reg, home_reg;
    logic [pme_pkg::NUM_CODES-1:0] seen_reg;

    logic [AW-1:0] ea, eb, es, ev, en;
    logic          g_rd, g_wr, g_sw, g_inv, g_fwd, g_bwd, accept;
    logic [AW:0]   tidx_sum;
    logic [AW-1:0] tidx;

    logic                         tour_we;
    logic [AW-1:0]                tour_wa, tour_ra;
    logic [pme_pkg::CITY_W-1:0]   tour_wd, tour_rdata, tmp_rdata;

    assign ea = AW'(first_index);
    assign eb = AW'(second_index);
    assign es = AW'(amount);
    assign ev = AW'(city_value);
    assign en = AW'(city_count);

    assign g_rd  = ea < en;
    assign g_wr  = (ea != '0) && (ea < en) && (ev != '0) && (ev < en);
    assign g_sw  = (ea != '0) && (ea < en) && (eb != '0) && (eb < en);
    assign g_inv = (eb > ea + AW'(1)) && (eb <= en);
    assign g_fwd = (ea != '0) && (eb > ea) && (es != '0) && (eb + es <= en);
    assign g_bwd = (eb < en) && (eb > ea) && (es != '0) && (ea > es);

    assign cmd_ready = state_reg == S_IDLE;
    assign accept    = cmd_valid && cmd_ready;

    assign tidx_sum = {1'b0, k_reg[AW-1:0]} + {1'b0, r_reg};
    assign tidx     = (tidx_sum >= {1'b0, len_reg}) ? AW'(tidx_sum - {1'b0, len_reg})
                                                  : tidx_sum[AW-1:0];

    always_comb begin
        tour_we = 1'b0;
        tour_wa = '0;
        tour_wd = '0;
        tour_ra = '0;
        unique case (state_reg)
            S_INIT: begin
                tour_we = 1'b1;
                tour_wa = k_reg[AW-1:0];
                tour_wd = k_reg[pme_pkg::CITY_W-1:0];
            end
            S_IDLE: begin
                tour_we = accept && (kind == pme_pkg::KIND_WRITE) && g_wr;
                tour_wa = ea;
                tour_wd = city_value;
            end
            S_RD:  tour_ra = a_reg;
            S_PA:  tour_ra = p_reg;
            S_PB:  tour_ra = q_reg;
            S_PW1: begin
                tour_we = 1'b1;
                tour_wa = p_reg;
                tour_wd = tour_rdata;
            end
            S_PW2: begin
                tour_we = 1'b1;
                tour_wa = q_reg;
                tour_wd = va_reg;
            end
            S_C1:  tour_ra = lo_reg + k_reg[AW-1:0];
            S_C2: begin
                tour_we = pend_reg;
                tour_wa = lo_reg + kd_reg;
                tour_wd = tmp_rdata;
            end
            S_CK:  tour_ra = k_reg[AW-1:0];
            default: ;
        endcase
    end

    pme_ram #(.DEPTH(MAX_CITIES), .W(pme_pkg::CITY_W)) u_tour (
        .aclk  (aclk),
        .we    (tour_we),
        .waddr (tour_wa[IDX_W-1:0]),
        .wdata (tour_wd),
        .raddr (tour_ra[IDX_W-1:0]),
        .rdata (tour_rdata)
    );

    pme_ram #(.DEPTH(MAX_CITIES), .W(pme_pkg::CITY_W)) u_scratch (
        .aclk  (aclk),
        .we    ((state_reg == S_C1) && pend_reg),
        .waddr (kd_reg[IDX_W-1:0]),
        .wdata (tour_rdata),
        .raddr (k_reg[IDX_W-1:0]),
        .rdata (tmp_rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT: begin
                if (k_reg == KW'(MAX_CITIES - 1)) begin
                    state_next = op_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (kind)
                        pme_pkg::KIND_IDENT: state_next = S_INIT;
                        pme_pkg::KIND_READ:  state_next = g_rd ? S_RD : S_DONE;
                        pme_pkg::KIND_WRITE: state_next = S_DONE;
                        pme_pkg::KIND_SWAP:  state_next = g_sw ? S_PA : S_DONE;
                        pme_pkg::KIND_INV: begin
                            if (!g_inv) begin
                                state_next = S_DONE;
                            end else if (ea == '0 && ((eb - ea) >> 1) == AW'(1)) begin
                                state_next = S_DONE;
                            end else begin
                                state_next = S_PA;
                            end
                        end
                        pme_pkg::KIND_FWD:   state_next = g_fwd ? S_C1 : S_DONE;
                        pme_pkg::KIND_BWD:   state_next = g_bwd ? S_C1 : S_DONE;
                        pme_pkg::KIND_CHECK: state_next = S_CK;
                        default:             state_next = S_DONE;
                    endcase
                end
            end
            S_RD:    state_next = S_RDOUT;
            S_RDOUT: state_next = S_DONE;
            S_PA:    state_next = S_PB;
            S_PB:    state_next = S_PW1;
            S_PW1:   state_next = S_PW2;
            S_PW2:   state_next = (pairs_reg == AW'(1)) ? S_DONE : S_PA;
            S_C1:    state_next = (k_reg == KW'(len_reg)) ? S_C2 : S_C1;
            S_C2:    state_next = (k_reg == KW'(len_reg)) ? S_DONE : S_C2;
            S_CK:    state_next = (k_reg == KW'(en)) ? S_DONE : S_CK;
            S_DONE:  state_next = res_ack ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            k_reg     <= '0;
            op_reg    <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= 1'b0;
            unique case (state_reg)
                S_INIT: begin
                    k_reg <= k_reg + KW'(1);
                end
                S_IDLE: begin
                    k_reg     <= '0;
                    rd_reg    <= '0;
                    ok_reg    <= 1'b0;
                    norep_reg <= 1'b0;
                    home_reg  <= 1'b0;
                    a_reg     <= ea;
                    if (accept) begin
                        unique case (kind)
                            pme_pkg::KIND_IDENT: begin
                                op_reg <= 1'b1;
                                ok_reg <= 1'b1;
                            end
                            pme_pkg::KIND_READ:  ok_reg <= g_rd;
                            pme_pkg::KIND_WRITE: ok_reg <= g_wr;
                            pme_pkg::KIND_SWAP: begin
                                ok_reg    <= g_sw;
                                p_reg     <= ea;
                                q_reg     <= eb;
                                pairs_reg <= AW'(1);
                            end
                            pme_pkg::KIND_INV: begin
                                ok_reg <= g_inv;
                                if (ea == '0) begin
                                    p_reg     <= AW'(1);
                                    q_reg     <= eb - AW'(2);
                                    pairs_reg <= ((eb - ea) >> 1) - AW'(1);
                                end else begin
                                    p_reg     <= ea;
                                    q_reg     <= eb - AW'(1);
                                    pairs_reg <= (eb - ea) >> 1;
                                end
                            end
                            pme_pkg::KIND_FWD: begin
                                ok_reg  <= g_fwd;
                                lo_reg  <= ea;
                                len_reg <= eb + es - ea;
                                r_reg   <= es;
                            end
                            pme_pkg::KIND_BWD: begin
                                ok_reg  <= g_bwd;
                                lo_reg  <= ea - es;
                                len_reg <= eb - ea + es;
                                r_reg   <= eb - ea;
                            end
                            pme_pkg::KIND_CHECK: begin
                                ok_reg    <= 1'b1;
                                norep_reg <= 1'b1;
                                seen_reg  <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RDOUT: rd_reg <= tour_rdata;
                S_PB:    va_reg <= tour_rdata;
                S_PW2: begin
                    pairs_reg <= pairs_reg - AW'(1);
                    p_reg     <= p_reg + AW'(1);
                    q_reg     <= q_reg - AW'(1);
                end
                S_C1: begin
                    pend_reg <= k_reg < KW'(len_reg);
                    kd_reg   <= tidx;
                    if (k_reg == KW'(len_reg)) begin
                        k_reg <= '0;
                    end else begin
                        k_reg <= k_reg + KW'(1);
                    end
                end
                S_C2: begin
                    pend_reg <= k_reg < KW'(len_reg);
                    kd_reg   <= k_reg[AW-1:0];
                    k_reg    <= k_reg + KW'(1);
                end
                S_CK: begin
                    pend_reg <= k_reg < KW'(en);
                    kd_reg   <= k_reg[AW-1:0];
                    k_reg    <= k_reg + KW'(1);
                    if (pend_reg) begin
                        if (kd_reg == '0) begin
                            home_reg <= tour_rdata == '0;
                        end else begin
                            if (seen_reg[tour_rdata]) begin
                                norep_reg <= 1'b0;
                            end
                            seen_reg[tour_rdata] <= 1'b1;
                        end
                    end
                end
                S_DONE: op_reg <= 1'b0;
                default: ;
            endcase
        end
    end

    assign res.valid       = state_reg == S_DONE;
    assign res.read_value  = rd_reg;
    assign res.applied     = ok_reg;
    assign res.no_repeat   = norep_reg;
    assign res.starts_home = home_reg;

endmodule

// File: hw/rtl/permutation_mutation_engine_core.sv
// ----------------------------------------------------------------------------
// permutation_mutation_engine_core
// Tour mutation engine: one operation word in, one result word out.
// ----------------------------------------------------------------------------
// Input words arrive on s_ (operation code on s_tuser, operands on s_tdata);
// one result word per operation leaves on m_. cfg_we/cfg_wdata set the
// number of positions in use, only while no operation is in flight: the
// user must keep to this, the block itself does not enforce it. One
// operation is worked at a time, through the tour memory's one read and
// one write port (one entry per cycle). Writes and reads touch one entry,
// swap and invert exchange entry pairs, a shift rotates its segment through
// a scratch memory, a check scans city_count entries; identity rewrites all.
// Results sit in an output register, so the next word is taken while the
// previous result still waits for m_tready; a stall longer than that holds
// the engine in its final state and s_tready low.
// After reset the tour memory is loaded with identity, with s_tready low;
// the count register resets to MAX_CITIES, capped at 64.
// ----------------------------------------------------------------------------
module permutation_mutation_engine_core #(
    parameter int MAX_CITIES = pme_pkg::MAX_CITIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // first_index, second_index, amount, city_value
    input  logic [2:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // read_value, applied, no_repeat, starts_home
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata
);

    logic [pme_pkg::FIELD_W-1:0] city_count_reg;
    logic                        out_valid_reg;
    logic [8:0]                  out_data_reg;
    pme_pkg::res_t               res;
    logic                        res_ack;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            city_count_reg <= (MAX_CITIES < 64) ? pme_pkg::FIELD_W'(MAX_CITIES)
                                                : pme_pkg::FIELD_W'(64);
        end else if (cfg_we) begin
            if (cfg_wdata < 7'd2) begin
                city_count_reg <= 7'd2;
            end else if (int'(cfg_wdata) > MAX_CITIES) begin
                city_count_reg <= pme_pkg::FIELD_W'(MAX_CITIES);
            end else begin
                city_count_reg <= cfg_wdata;
            end
        end
    end

    pme_ctrl #(.MAX_CITIES(MAX_CITIES)) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .city_count   (city_count_reg),
        .cmd_valid    (s_tvalid),
        .cmd_ready    (s_tready),
        .kind         (s_tuser),
        .first_index  (s_tdata[6:0]),
        .second_index (s_tdata[13:7]),
        .amount       (s_tdata[19:14]),
        .city_value   (s_tdata[25:20]),
        .res          (res),
        .res_ack      (res_ack)
    );

    assign res_ack = res.valid && (!out_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ack) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ack) begin
            out_data_reg <= {res.starts_home, res.no_repeat, res.applied, res.read_value};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_data_reg};

endmodule

// File: hw/rtl/pme_checker.sv
// ----------------------------------------------------------------------------
// pme_checker
// Port-level checks on the mutation engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "permutation_mutation_engine_core_macros.svh"

module pme_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // hold a stalled result
    `PME_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // one operation at a time
    `PME_ASSERT_NXT(a_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // refused operations report no data
    `PME_ASSERT_IMP(a_refused, aclk, aresetn, m_tvalid && !m_tdata[6], m_tdata[5:0] == 6'd0)
    // no result straight out of reset
    `PME_ASSERT_NXT_RAW(a_reset, aclk, !aresetn, !m_tvalid && !s_tready)

endmodule

bind permutation_mutation_engine_core pme_checker u_pme_checker (.*);

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives operation words into the tour mutation engine, keeps a tour of its
// own to predict each result word, and compares every result field by field.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NCITY = pme_pkg::MAX_CITIES_DEF;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic                       starts_home;
        logic                       no_repeat;
        logic                       applied;
        logic [pme_pkg::CITY_W-1:0] read_value;
    } outcome_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [6:0]  cfg_wdata = '0;

    logic [pme_pkg::CITY_W-1:0] tour_copy [NCITY];
    int                count_copy;
    outcome_t          pending_outcomes [$];
    int                failures = 0;
    int                idle_cycles = 0;
    int                stall_mode = 0;
    int                burst_left = 0;

    permutation_mutation_engine_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void swap_entries(int p, int q);
        logic [pme_pkg::CITY_W-1:0] t;
        if (p <= 0 || q <= 0 || p >= count_copy || q >= count_copy) return;
        t = tour_copy[p];
        tour_copy[p] = tour_copy[q];
        tour_copy[q] = t;
    endfunction

    function automatic void rotate_tour(int lo, int hi, int r);
        logic [pme_pkg::CITY_W-1:0] tmp [NCITY];
        int len;
        len = hi - lo;
        for (int k = 0; k < len; k++) tmp[(k + r) % len] = tour_copy[lo + k];
        for (int k = 0; k < len; k++) tour_copy[lo + k] = tmp[k];
    endfunction

    function automatic outcome_t mutate_tour(logic [2:0] kind, int a, int b, int s, int v);
        outcome_t o;
        int n;
        o = '0;
        n = count_copy;
        case (kind)
            pme_pkg::KIND_IDENT: begin
                for (int i = 0; i < NCITY; i++) tour_copy[i] = i[pme_pkg::CITY_W-1:0];
                o.applied = 1'b1;
            end
            pme_pkg::KIND_READ: if (a < n) begin
                o.read_value = tour_copy[a];
                o.applied = 1'b1;
            end
            pme_pkg::KIND_WRITE: if (a != 0 && a < n && v > 0 && v < n) begin
                tour_copy[a] = v[pme_pkg::CITY_W-1:0];
                o.applied = 1'b1;
            end
            pme_pkg::KIND_SWAP: if (a > 0 && a < n && b > 0 && b < n) begin
                swap_entries(a, b);
                o.applied = 1'b1;
            end
            pme_pkg::KIND_INV: if (b - a > 1 && b <= n) begin
                for (int i = 0; i < (b - a) / 2; i++) swap_entries(a + i, b - 1 - i);
                o.applied = 1'b1;
            end
            pme_pkg::KIND_FWD: if (a > 0 && b > a && s > 0 && b + s <= n) begin
                rotate_tour(a, b + s, s);
                o.applied = 1'b1;
            end
            pme_pkg::KIND_BWD: if (b < n && b > a && s > 0 && a - s > 0) begin
                rotate_tour(a - s, b, b - a);
                o.applied = 1'b1;
            end
            default: begin
                o.no_repeat = 1'b1;
                for (int i = 1; i < n; i++)
                    for (int j = i + 1; j < n; j++)
                        if (tour_copy[i] == tour_copy[j]) o.no_repeat = 1'b0;
                o.starts_home = (tour_copy[0] == 0);
                o.applied = 1'b1;
            end
        endcase
        return o;
    endfunction

    task automatic send_word(logic [2:0] kind, int a, int b, int s, int v);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'd0, v[5:0], s[5:0], b[6:0], a[6:0]};
        do @(posedge aclk); while (!s_tready);
        pending_outcomes.push_back(mutate_tour(kind, a, b, s, v));
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic set_count(int value);
        int c;
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value[6:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        c = value;
        if (c < 2) c = 2;
        if (c > NCITY) c = NCITY;
        count_copy = c;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            outcome_t got, want;
            got = m_tdata[8:0];
            if (pending_outcomes.size() == 0) begin
                $error("result word with none expected");
                failures++;
            end else begin
                want = pending_outcomes.pop_front();
                if (got.read_value !== want.read_value) begin
                    $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
                    failures++;
                end
                if (got.applied !== want.applied) begin
                    $error("applied: expected %0d, got %0d", want.applied, got.applied);
                    failures++;
                end
                if (got.no_repeat !== want.no_repeat) begin
                    $error("no_repeat: expected %0d, got %0d", want.no_repeat, got.no_repeat);
                    failures++;
                end
                if (got.starts_home !== want.starts_home) begin
                    $error("starts_home: expected %0d, got %0d",
                           want.starts_home, got.starts_home);
                    failures++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic test_directed;
        send_word(pme_pkg::KIND_CHECK, 0, 0, 0, 0);
        send_word(pme_pkg::KIND_READ, 63, 0, 0, 0);
        send_word(pme_pkg::KIND_READ, 64, 0, 0, 0);
        send_word(pme_pkg::KIND_READ, 127, 127, 63, 63);
        send_word(pme_pkg::KIND_WRITE, 0, 0, 0, 5);
        send_word(pme_pkg::KIND_WRITE, 5, 0, 0, 0);
        send_word(pme_pkg::KIND_WRITE, 5, 0, 0, 7);
        send_word(pme_pkg::KIND_CHECK, 0, 0, 0, 0);
        send_word(pme_pkg::KIND_SWAP, 3, 3, 0, 0);
        send_word(pme_pkg::KIND_SWAP, 0, 4, 0, 0);
        send_word(pme_pkg::KIND_SWAP, 1, 63, 0, 0);
        send_word(pme_pkg::KIND_INV, 0, 64, 0, 0);
        send_word(pme_pkg::KIND_INV, 5, 6, 0, 0);
        send_word(pme_pkg::KIND_INV, 1, 65, 0, 0);
        send_word(pme_pkg::KIND_FWD, 1, 2, 62, 0);
        send_word(pme_pkg::KIND_FWD, 0, 5, 2, 0);
        send_word(pme_pkg::KIND_FWD, 1, 63, 1, 0);
        send_word(pme_pkg::KIND_BWD, 62, 63, 61, 0);
        send_word(pme_pkg::KIND_BWD, 2, 5, 2, 0);
        send_word(pme_pkg::KIND_BWD, 10, 20, 0, 0);
        send_word(pme_pkg::KIND_CHECK, 0, 0, 0, 0);
        send_word(pme_pkg::KIND_IDENT, 0, 0, 0, 0);
        send_word(pme_pkg::KIND_CHECK, 0, 0, 0, 0);
    endtask

    task automatic send_random(int how_many);
        int n, a, b, k;
        for (int i = 0; i < how_many; i++) begin
            n = count_copy;
            k = $urandom_range(0, 7);
            if (k == pme_pkg::KIND_IDENT && $urandom_range(0, 3) != 0) k = pme_pkg::KIND_CHECK;
            if ($urandom_range(0, 9) == 0) begin
                send_word(k[2:0], $urandom_range(0, 127), $urandom_range(0, 127),
                          $urandom_range(0, 63), $urandom_range(0, 63));
            end else begin
                a = $urandom_range(0, n);
                b = $urandom_range(0, n);
                send_word(k[2:0], a, b, $urandom_range(0, n / 2), $urandom_range(0, n));
            end
        end
    endtask

    task automatic test_counts;
        int settings [6] = '{2, 0, 127, 5, 17, 64};
        foreach (settings[i]) begin
            set_count(settings[i]);
            send_random(150);
            if (i == 2) send_word(pme_pkg::KIND_IDENT, 0, 0, 0, 0);
        end
    endtask

    initial begin
        for (int i = 0; i < NCITY; i++) tour_copy[i] = i[pme_pkg::CITY_W-1:0];
        count_copy = 64;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        send_random(500);
        test_counts();
        drain();
        if (failures == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
